>>> design/ota_st_pkg.sv
// ----------------------------------------------------------------------------
// ota_st_pkg
// Types and constants for the update-target station table.
// ----------------------------------------------------------------------------
package ota_st_pkg;

	localparam int TABLE_DEPTH = 8;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int MAC_W       = 48;
	localparam int COUNT_W     = 4;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
	localparam logic [7:0]         STATUS_FAIL = 8'hff;

	typedef enum logic [2:0] {
		OP_SCAN     = 3'd0,
		OP_DATA     = 3'd1,
		OP_SETPARAM = 3'd2,
		OP_CLR_ALL  = 3'd3,
		OP_QUERY    = 3'd4,
		OP_CLR_OFF  = 3'd5,
		OP_OTHER    = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		RES_NONE     = 2'd0,
		RES_RECORDED = 2'd1,
		RES_DATA     = 2'd2,
		RES_CONFIG   = 2'd3
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_READ   = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [15:0]      chip;
		logic [31:0]      version;
		logic [31:0]      svn;
		logic [31:0]      resume_ofs;
	} entry_t;

endpackage

>>> design/ota_station_table.sv
// ----------------------------------------------------------------------------
// ota_station_table
// Station table keyed by MAC: scan reports, chunk acks, offset queries.
// ----------------------------------------------------------------------------
// One request at a time. Entries live in a single-port table memory with a
// registered read; one MAC comparator walks it entry by entry (read, then
// compare), stopping at the first online match. A request that carries a MAC
// goes from accept through a read and a compare per entry up to the match, or
// over all TABLE_DEPTH entries on a miss, then to finish; clear-all and other
// requests go straight from accept to finish. A finished request waits while
// the previous result is still held by the receiver. The next request can be
// taken in the cycle after the result is registered. Online marks are
// flip-flops, so reset and clear-all take effect at once; no clearing pass
// is needed.
module ota_station_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  op,
	input  logic [ota_st_pkg::MAC_W-1:0] station_mac,
	input  logic [15:0]                 chip_id,
	input  logic [31:0]                 fw_version,
	input  logic [31:0]                 src_revision,
	input  logic [31:0]                 chunk_offset,
	input  logic [15:0]                 chunk_length,
	input  logic [7:0]                  frame_status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  result_code,
	output logic [31:0]                 next_offset,
	output logic [ota_st_pkg::COUNT_W-1:0] station_count,
	output logic                        station_found
);
	import ota_st_pkg::*;

	// control
	state_t                 state_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   hit_q;
	logic [TABLE_DEPTH-1:0] online_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   out_valid_q;

	// request payload
	op_t              op_q;
	logic [MAC_W-1:0] mac_q;
	logic [15:0]      chip_q;
	logic [31:0]      ver_q;
	logic [31:0]      svn_q;
	logic [31:0]      off_q;
	logic [15:0]      len_q;
	logic [7:0]       status_q;

	// result register
	logic [1:0]         res_code_q;
	logic [31:0]        res_off_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_found_q;

	// table memory
	entry_t mem_q [TABLE_DEPTH];
	entry_t rdata_q;

	logic             accept;
	logic             uses_mac;
	logic             finish_go;
	logic             is_match;
	logic             last_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             status_ok;

	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	entry_t                 wr_data;
	logic [1:0]             code_nxt;
	logic [31:0]            off_nxt;
	logic [COUNT_W-1:0]     count_nxt;
	logic [TABLE_DEPTH-1:0] online_nxt;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign is_match  = online_q[idx_q] && (rdata_q.mac == mac_q);
	assign last_idx  = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign status_ok = (status_q != STATUS_FAIL);

	always_comb begin
		case (op)
			OP_SCAN, OP_DATA, OP_SETPARAM, OP_QUERY, OP_CLR_OFF: uses_mac = 1'b1;
			default: uses_mac = 1'b0;
		endcase
	end

	// lowest offline slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!online_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// modify step: rdata_q still holds the matched entry when hit_q is set
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = idx_q;
		wr_data    = rdata_q;
		code_nxt   = RES_NONE;
		off_nxt    = hit_q ? rdata_q.resume_ofs : 32'd0;
		count_nxt  = count_q;
		online_nxt = online_q;
		case (op_q)
			OP_SCAN: begin
				if (hit_q) begin
					wr_en        = 1'b1;
					wr_data.chip    = chip_q;
					wr_data.version = ver_q;
					wr_data.svn     = svn_q;
					code_nxt     = RES_RECORDED;
				end else if (free_found) begin
					wr_en      = 1'b1;
					wr_addr    = free_idx;
					wr_data    = '{mac: mac_q, chip: chip_q, version: ver_q,
						svn: svn_q, resume_ofs: 32'd0};
					online_nxt[free_idx] = 1'b1;
					if (count_q < COUNT_MAX) begin
						count_nxt = count_q + COUNT_W'(1);
					end
					code_nxt   = RES_RECORDED;
					off_nxt    = 32'd0;
				end
			end
			OP_DATA: begin
				code_nxt = RES_DATA;
				if (hit_q && status_ok) begin
					wr_en              = 1'b1;
					wr_data.resume_ofs = off_q + {16'd0, len_q};
					off_nxt            = off_q + {16'd0, len_q};
				end
			end
			OP_SETPARAM: begin
				if (hit_q && status_ok) begin
					code_nxt = RES_CONFIG;
				end
			end
			OP_CLR_ALL: begin
				online_nxt = '0;
				count_nxt  = '0;
			end
			OP_QUERY: begin
			end
			OP_CLR_OFF: begin
				if (hit_q) begin
					wr_en              = 1'b1;
					wr_data.resume_ofs = 32'd0;
					off_nxt            = 32'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			online_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= uses_mac ? ST_READ : ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (is_match) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (last_idx) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						online_q <= online_nxt;
						count_q  <= count_nxt;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(op);
			mac_q    <= station_mac;
			chip_q   <= chip_id;
			ver_q    <= fw_version;
			svn_q    <= src_revision;
			off_q    <= chunk_offset;
			len_q    <= chunk_length;
			status_q <= frame_status;
		end
		if (finish_go) begin
			res_code_q  <= code_nxt;
			res_off_q   <= off_nxt;
			res_count_q <= count_nxt;
			res_found_q <= hit_q;
		end
	end

	// table memory: one port, registered read
	always_ff @(posedge clk) begin
		if (finish_go && wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end else if (state_q == ST_READ) begin
			rdata_q <= mem_q[idx_q];
		end
	end

	assign out_valid     = out_valid_q;
	assign result_code   = res_code_q;
	assign next_offset   = res_off_q;
	assign station_count = res_count_q;
	assign station_found = res_found_q;

	// online marks and the count only move together
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == COUNT_W'($countones(online_q)))
	else $error("station count out of step with online marks");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
	else $error("accepted request did not start");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_code_q == RES_CONFIG) |-> res_found_q)
	else $error("config update reported for unknown station");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) && is_match |=> hit_q && (state_q == ST_FINISH))
	else $error("match not carried into finish");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_count_q <= COUNT_W'(TABLE_DEPTH))
	else $error("station count beyond table depth");

endmodule

>>> tb/sv/ota_station_table_tb.sv
// ----------------------------------------------------------------------------
// ota_station_table_tb
// Self-checking bench for the MAC-keyed update-target station table.
// A directed table walks reset state, field extremes, the full table, offset
// wrap, failed responses and every op. A constrained-by-hand random run follows
// over a small MAC pool, so hits, misses, refills and clears all recur. Each
// request is predicted by a behavioral copy of the table, and the oldest
// expected result (the prediction, or a directed row's fixed one) is compared
// with each accepted result. Sender and receiver idle at several rates.
// ----------------------------------------------------------------------------
module ota_station_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ota_st_pkg::*;

	localparam logic [2:0]  OP_RESERVED   = 3'd7;  // outside the enum, must be ignored
	localparam logic [47:0] MAC_ZERO      = 48'h0;
	localparam logic [47:0] MAC_ONES      = 48'hffff_ffff_ffff;
	localparam logic [47:0] MAC_STRANGER  = 48'h0a1b_2c3d_4e5f;
	localparam int          MAC_POOL_SIZE = 12;
	localparam int          RANDOM_ITEMS  = 125;  // per idling phase
	localparam int          STALL_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES  = 40;
	localparam int          DIRECTED_ROWS = 25;
	localparam int          SEND_IDLE [4] = '{0, 47, 0, 26};
	localparam int          RECV_STALL [4] = '{0, 0, 47, 26};

	typedef struct packed {
		logic [2:0]  op;
		logic [47:0] mac;
		logic [15:0] chip;
		logic [31:0] version;
		logic [31:0] svn;
		logic [31:0] offset;
		logic [15:0] length;
		logic [7:0]  status;
	} table_req_t;

	typedef struct packed {
		res_t        code;
		logic [31:0] resume_ofs;
		logic [3:0]  count;
		logic        found;
	} table_result_t;

	typedef struct packed {
		table_req_t    req;
		logic          fixed;
		table_result_t want;
	} directed_row_t;

	localparam logic FIXED    = 1'b1;
	localparam logic BY_MODEL = 1'b0;

	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// fresh table: a cleared slot never matches, not even MAC zero
		'{'{OP_QUERY, MAC_ZERO, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd0, 1'b0}},
		'{'{OP_SCAN, MAC_ZERO, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_RECORDED, 32'h0, 4'd1, 1'b0}},
		'{'{OP_SCAN, MAC_ONES, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			16'hffff, 8'hff}, FIXED, '{RES_RECORDED, 32'h0, 4'd2, 1'b0}},
		// refresh of a known station keeps the count
		'{'{OP_SCAN, MAC_ONES, 16'h1234, 32'h1, 32'h2, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_RECORDED, 32'h0, 4'd2, 1'b1}},
		// offset + length wraps at 32 bits
		'{'{OP_DATA, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'hffff_ffff, 16'hffff, 8'h00},
			FIXED, '{RES_DATA, 32'h0000_fffe, 4'd2, 1'b1}},
		'{'{OP_DATA, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h10, STATUS_FAIL},
			FIXED, '{RES_DATA, 32'h0000_fffe, 4'd2, 1'b1}},
		'{'{OP_DATA, MAC_STRANGER, 16'h0, 32'h0, 32'h0, 32'h100, 16'h10, 8'h00},
			FIXED, '{RES_DATA, 32'h0, 4'd2, 1'b0}},
		'{'{OP_SETPARAM, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_CONFIG, 32'h0000_fffe, 4'd2, 1'b1}},
		'{'{OP_SETPARAM, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, STATUS_FAIL},
			FIXED, '{RES_NONE, 32'h0000_fffe, 4'd2, 1'b1}},
		'{'{OP_SETPARAM, MAC_STRANGER, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd2, 1'b0}},
		'{'{OP_QUERY, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0000_fffe, 4'd2, 1'b1}},
		'{'{OP_CLR_OFF, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd2, 1'b1}},
		'{'{OP_CLR_OFF, MAC_STRANGER, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd2, 1'b0}},
		// ops without a MAC never report a match
		'{'{OP_OTHER, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd2, 1'b0}},
		'{'{OP_RESERVED, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd2, 1'b0}},
		// fill the remaining six slots
		'{'{OP_SCAN, 48'h1, 16'h0101, 32'h11, 32'h21, 32'h0, 16'h0, 8'h00},
			BY_MODEL, '0},
		'{'{OP_SCAN, 48'h2, 16'h0202, 32'h12, 32'h22, 32'h0, 16'h0, 8'h00},
			BY_MODEL, '0},
		'{'{OP_SCAN, 48'h3, 16'h0303, 32'h13, 32'h23, 32'h0, 16'h0, 8'h00},
			BY_MODEL, '0},
		'{'{OP_SCAN, 48'h4, 16'h0404, 32'h14, 32'h24, 32'h0, 16'h0, 8'h00},
			BY_MODEL, '0},
		'{'{OP_SCAN, 48'h5, 16'h0505, 32'h15, 32'h25, 32'h0, 16'h0, 8'h00},
			BY_MODEL, '0},
		'{'{OP_SCAN, 48'h6, 16'h0606, 32'h16, 32'h26, 32'h0, 16'h0, 8'h00},
			BY_MODEL, '0},
		'{'{OP_DATA, 48'h3, 16'h0, 32'h0, 32'h0, 32'h1000, 16'h200, 8'hfe},
			BY_MODEL, '0},
		// table full: unknown station is dropped
		'{'{OP_SCAN, MAC_STRANGER, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd8, 1'b0}},
		'{'{OP_CLR_ALL, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd0, 1'b0}},
		'{'{OP_QUERY, MAC_ONES, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0, 8'h00},
			FIXED, '{RES_NONE, 32'h0, 4'd0, 1'b0}}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [2:0]          op;
	logic [MAC_W-1:0]    station_mac;
	logic [15:0]         chip_id;
	logic [31:0]         fw_version;
	logic [31:0]         src_revision;
	logic [31:0]         chunk_offset;
	logic [15:0]         chunk_length;
	logic [7:0]          frame_status;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          result_code;
	logic [31:0]         next_offset;
	logic [COUNT_W-1:0]  station_count;
	logic                station_found;

	// shadow copy of the station table
	logic [47:0]         shadow_mac [TABLE_DEPTH];
	logic                shadow_online [TABLE_DEPTH];
	logic [15:0]         shadow_chip [TABLE_DEPTH];
	logic [31:0]         shadow_version [TABLE_DEPTH];
	logic [31:0]         shadow_svn [TABLE_DEPTH];
	logic [31:0]         shadow_resume_ofs [TABLE_DEPTH];
	logic [COUNT_W-1:0]  shadow_count;

	table_result_t       pending_results [$];
	table_result_t       oldest;
	logic [47:0]         mac_pool [MAC_POOL_SIZE];
	int                  mismatches;
	int                  send_idle_pct;
	int                  recv_stall_pct;

	ota_station_table u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.station_mac   (station_mac),
		.chip_id       (chip_id),
		.fw_version    (fw_version),
		.src_revision  (src_revision),
		.chunk_offset  (chunk_offset),
		.chunk_length  (chunk_length),
		.frame_status  (frame_status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_code   (result_code),
		.next_offset   (next_offset),
		.station_count (station_count),
		.station_found (station_found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void wipe_shadow();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			shadow_mac[i]        = '0;
			shadow_online[i]     = 1'b0;
			shadow_chip[i]       = '0;
			shadow_version[i]    = '0;
			shadow_svn[i]        = '0;
			shadow_resume_ofs[i] = '0;
		end
		shadow_count = '0;
	endfunction

	function automatic table_result_t apply_request(input table_req_t req);
		table_result_t res;
		int            hit;
		int            slot;
		logic          uses_mac;
		res = '{RES_NONE, 32'h0, 4'd0, 1'b0};
		hit = -1;
		uses_mac = (req.op == OP_SCAN) || (req.op == OP_DATA) || (req.op == OP_SETPARAM) ||
			(req.op == OP_QUERY) || (req.op == OP_CLR_OFF);
		if (uses_mac) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (hit < 0 && shadow_online[i] && shadow_mac[i] == req.mac)
					hit = i;
			end
		end
		slot = hit;
		case (req.op)
			OP_SCAN: begin
				if (slot < 0) begin
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (slot < 0 && !shadow_online[i])
							slot = i;
					end
					if (slot >= 0) begin
						shadow_mac[slot]        = req.mac;
						shadow_resume_ofs[slot] = '0;
						if (shadow_count < COUNT_MAX)
							shadow_count = shadow_count + 1'b1;
					end
				end
				if (slot >= 0) begin
					shadow_chip[slot]    = req.chip;
					shadow_version[slot] = req.version;
					shadow_svn[slot]     = req.svn;
					shadow_online[slot]  = 1'b1;
					res.code             = RES_RECORDED;
				end
			end
			OP_DATA: begin
				if (hit >= 0 && req.status != STATUS_FAIL)
					shadow_resume_ofs[hit] = req.offset + {16'h0, req.length};
				res.code = RES_DATA;
			end
			OP_SETPARAM: begin
				if (hit >= 0 && req.status != STATUS_FAIL)
					res.code = RES_CONFIG;
			end
			OP_CLR_ALL: begin
				wipe_shadow();
			end
			OP_CLR_OFF: begin
				if (hit >= 0)
					shadow_resume_ofs[hit] = '0;
			end
			default: ;
		endcase
		res.resume_ofs = (slot >= 0) ? shadow_resume_ofs[slot] : 32'h0;
		res.count      = shadow_count;
		res.found      = (hit >= 0);
		return res;
	endfunction

	function automatic table_req_t random_request();
		table_req_t req;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 30)      req.op = OP_SCAN;
		else if (pick < 50) req.op = OP_DATA;
		else if (pick < 62) req.op = OP_SETPARAM;
		else if (pick < 74) req.op = OP_QUERY;
		else if (pick < 84) req.op = OP_CLR_OFF;
		else if (pick < 87) req.op = OP_CLR_ALL;
		else if (pick < 94) req.op = OP_OTHER;
		else                req.op = OP_RESERVED;
		// mostly pooled MACs so lookups hit; a few strangers
		if ($urandom_range(9) == 0)
			req.mac = 48'({$urandom(), $urandom()});
		else
			req.mac = mac_pool[$urandom_range(MAC_POOL_SIZE - 1)];
		req.chip    = 16'($urandom());
		req.version = $urandom();
		req.svn     = $urandom();
		req.offset  = ($urandom_range(6) == 0) ? (32'hffff_0000 | 32'($urandom_range(16'hffff)))
			: $urandom();
		req.length  = 16'($urandom());
		req.status  = ($urandom_range(4) == 0) ? STATUS_FAIL : 8'($urandom_range(254));
		return req;
	endfunction

	// waits out the sender gap, then holds the request until it is taken
	task automatic send_request(input table_req_t req, input logic fixed,
			input table_result_t want);
		table_result_t predicted;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid     <= 1'b1;
		op           <= req.op;
		station_mac  <= req.mac;
		chip_id      <= req.chip;
		fw_version   <= req.version;
		src_revision <= req.svn;
		chunk_offset <= req.offset;
		chunk_length <= req.length;
		frame_status <= req.status;
		do @(posedge clk); while (!in_ready);
		predicted = apply_request(req);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got code %0d", $time,
					result_code);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("result_code", 32'(oldest.code), 32'(result_code));
				check_field("next_offset", oldest.resume_ofs, next_offset);
				check_field("station_count", 32'(oldest.count), 32'(station_count));
				check_field("station_found", 32'(oldest.found), 32'(station_found));
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
		$display("ota_station_table test failed");
		$finish;
	end

	initial begin
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		out_ready      = 1'b0;
		op             = OP_OTHER;
		station_mac    = '0;
		chip_id        = '0;
		fw_version     = '0;
		src_revision   = '0;
		chunk_offset   = '0;
		chunk_length   = '0;
		frame_status   = '0;
		wipe_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_request(DIRECTED[r].req, DIRECTED[r].fixed, DIRECTED[r].want);

		// pool holds both MAC extremes plus random ones; more MACs than slots
		mac_pool[0] = MAC_ZERO;
		mac_pool[1] = MAC_ONES;
		for (int i = 2; i < MAC_POOL_SIZE; i++)
			mac_pool[i] = 48'({$urandom(), $urandom()});

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			repeat (RANDOM_ITEMS)
				send_request(random_request(), BY_MODEL, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("ota_station_table test passed");
		else
			$display("ota_station_table test failed");
		$finish;
	end

endmodule
